// File: sv/sst_pkg.sv
// Package for the seed slot table: sizes, register indexes, state encoding
// and the command and status structs between controller and datapath.
// No dependencies; every other file of the block imports it.
package sst_pkg;

  // Table geometry.
  localparam int MAX_SLOTS  = 1024;
  localparam int MAX_SEEDS  = 8;
  localparam int RESULT_CAP = 8;
  localparam int SEEDS_CAP  = (MAX_SEEDS < RESULT_CAP) ? MAX_SEEDS : RESULT_CAP;

  localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int REM_W      = SLOT_W + 1;
  localparam int POS_W      = (SEEDS_CAP > 1) ? $clog2(SEEDS_CAP) : 1;
  localparam int NSEED_W    = $clog2(SEEDS_CAP + 1);
  localparam int SEED_DEPTH = MAX_SLOTS * (2 ** POS_W);

  // Field widths of the channels.
  localparam int ID_W      = 32;
  localparam int SCORE_W   = 32;
  localparam int SPOS_W    = 3;
  localparam int TICK_W    = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Configuration registers.
  localparam int SLOT_COUNT_W = 11;
  localparam int SEEDS_REG_W  = 4;
  localparam int STALE_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEEDS        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_WINDOW = 2'd2;

  localparam logic [SLOT_COUNT_W-1:0] DEF_SLOT_COUNT   = 11'd1024;
  localparam logic [SEEDS_REG_W-1:0]  DEF_SEEDS        = 4'd8;
  localparam logic [STALE_W-1:0]      DEF_STALE_WINDOW = 32'd4096;

  localparam logic signed [SCORE_W-1:0] SCORE_INF = 32'sh7FFF_FFFF;

  // Item kinds.
  localparam logic KIND_LOOKUP    = 1'b0;
  localparam logic KIND_WRITEBACK = 1'b1;

  // Iterative modulo: four quotient bits per cycle over a 32-bit dividend.
  localparam int MOD_RADIX_BITS = 4;
  localparam int MOD_STEPS      = ID_W / MOD_RADIX_BITS;
  localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [TICK_W-1:0]         age;
    logic [SEEDS_CAP-1:0]      mask;
  } sst_meta_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_META_RD,
    S_LK_META,
    S_LK_OUT,
    S_MISS,
    S_WB_DECIDE,
    S_WB_MASK
  } sst_state_t;

  typedef struct packed {
    logic capture;
    logic tick_inc;
    logic run_clear;
    logic mod_start;
    logic slot_from_mod;
    logic slot_from_run;
    logic meta_rd;
    logic k_clear;
    logic k_inc;
    logic wb_decide;
    logic wb_more;
    logic emit_miss;
    logic emit_seed;
    logic clear_step;
  } sst_cmd_t;

  typedef struct packed {
    logic req_lookup;
    logic req_pos0;
    logic req_wb_ok;
    logic req_more_ok;
    logic req_qid_neg;
    logic mod_done;
    logic cap_lookup;
    logic cap_pos0;
    logic meta_valid;
    logic last_seed;
    logic out_free;
    logic clear_last;
    logic cfg_hit;
  } sst_status_t;

endpackage

// File: sv/sst_ifs.sv
// Channel interfaces of the seed slot table: request items, result items
// and configuration writes. Depends on sst_pkg for the field widths.
interface sst_req_if import sst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [ID_W-1:0]    query_id;
  logic signed [ID_W-1:0]    seed_id;
  logic [SPOS_W-1:0]         seed_pos;
  logic signed [SCORE_W-1:0] score;
  logic                      score_finite;

  modport source (output valid, kind, query_id, seed_id, seed_pos, score, score_finite,
                  input ready);
  modport sink (input valid, kind, query_id, seed_id, seed_pos, score, score_finite,
                output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic signed [ID_W-1:0] out_seed;
  logic [SPOS_W-1:0]      out_pos;
  logic                   last;

  modport source (output valid, found, out_seed, out_pos, last, input ready);
  modport sink (input valid, found, out_seed, out_pos, last, output ready);
endinterface

interface sst_cfg_if import sst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/sst_mod_unit.sv
// Iterative remainder unit: non-negative query id modulo the slot count,
// four bits per cycle by restoring subtraction. Depends on sst_pkg.
module sst_mod_unit import sst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ID_W-2:0]   dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [SLOT_W-1:0] rem
);

  logic [ID_W-1:0]      dvd;
  logic [REM_W-1:0]     r;
  logic [REM_W-1:0]     r_next;
  logic [MOD_CNT_W-1:0] cnt;
  logic                 busy;

  // The partial remainder stays below the divisor, so a shift plus one
  // compare and subtract per bit keeps it in range.
  always_comb begin
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] d;
    d = REM_W'(divisor);
    t = r;
    for (int i = 0; i < MOD_RADIX_BITS; i++) begin
      t = {t[REM_W-2:0], dvd[ID_W-1-i]};
      if (t >= d) begin
        t = t - d;
      end
    end
    r_next = t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == MOD_CNT_W'(MOD_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {1'b0, dividend};
      r   <= '0;
    end else if (busy) begin
      dvd <= dvd << MOD_RADIX_BITS;
      r   <= r_next;
    end
  end

  assign rem = r[SLOT_W-1:0];

endmodule

// File: sv/sst_datapath.sv
// Datapath of the seed slot table: configuration registers, slot metadata
// and seed memories, tick counter, run state and result register.
// Depends on sst_pkg and instantiates sst_mod_unit.
module sst_datapath import sst_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  sst_cmd_t                  cmd,
  output sst_status_t               st,
  input  logic                      kind,
  input  logic signed [ID_W-1:0]    query_id,
  input  logic signed [ID_W-1:0]    seed_id,
  input  logic [SPOS_W-1:0]         seed_pos,
  input  logic signed [SCORE_W-1:0] score,
  input  logic                      score_finite,
  input  logic                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DAT_W-1:0]      cfg_data,
  input  logic                      rsp_ready,
  output logic                      rsp_valid,
  output logic                      found,
  output logic signed [ID_W-1:0]    out_seed,
  output logic [SPOS_W-1:0]         out_pos,
  output logic                      last
);

  logic [SLOT_COUNT_W-1:0] slot_count;
  logic [SEEDS_REG_W-1:0]  seeds_per_slot;
  logic [STALE_W-1:0]      stale_window;
  logic [CNT_W-1:0]        eff_slots;
  logic [NSEED_W-1:0]      nseeds;
  logic                    cfg_hit;

  logic                      cap_kind;
  logic signed [ID_W-1:0]    cap_seed;
  logic [SPOS_W-1:0]         cap_pos;
  logic signed [SCORE_W-1:0] cap_score;

  logic [TICK_W-1:0] tick;
  logic              run_accept;
  logic [SLOT_W-1:0] run_slot;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] clr_idx;
  logic [POS_W-1:0]  k;
  logic [POS_W-1:0]  k_next;

  logic              mod_done;
  logic [SLOT_W-1:0] mod_rem;

  sst_meta_t         meta_mem [MAX_SLOTS];
  sst_meta_t         meta_q;
  sst_meta_t         meta_wdata;
  logic              meta_we;
  logic [SLOT_W-1:0] meta_waddr;

  logic signed [ID_W-1:0]  seed_mem [SEED_DEPTH];
  logic signed [ID_W-1:0]  seed_q;
  logic                    seed_we;
  logic [POS_W-1:0]        seed_wpos;
  logic                    repl;
  logic [SEEDS_CAP-1:0]    pos_bit;

  // Configuration registers; a write to a listed register also restarts
  // the clearing pass.
  assign cfg_hit = cfg_valid && ((cfg_index == REG_SLOT_COUNT) || (cfg_index == REG_SEEDS) ||
                                 (cfg_index == REG_STALE_WINDOW));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count     <= DEF_SLOT_COUNT;
      seeds_per_slot <= DEF_SEEDS;
      stale_window   <= DEF_STALE_WINDOW;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLOT_COUNT:   slot_count     <= cfg_data[SLOT_COUNT_W-1:0];
        REG_SEEDS:        seeds_per_slot <= cfg_data[SEEDS_REG_W-1:0];
        REG_STALE_WINDOW: stale_window   <= cfg_data[STALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slot_count == '0) begin
      eff_slots = CNT_W'(1);
    end else if (32'(slot_count) > 32'(MAX_SLOTS)) begin
      eff_slots = CNT_W'(MAX_SLOTS);
    end else begin
      eff_slots = CNT_W'(slot_count);
    end
    if (seeds_per_slot == '0) begin
      nseeds = NSEED_W'(1);
    end else if (32'(seeds_per_slot) > 32'(SEEDS_CAP)) begin
      nseeds = NSEED_W'(SEEDS_CAP);
    end else begin
      nseeds = NSEED_W'(seeds_per_slot);
    end
  end

  sst_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (query_id[ID_W-2:0]),
    .divisor  (eff_slots),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_kind  <= kind;
      cap_seed  <= seed_id;
      cap_pos   <= seed_pos;
      cap_score <= score;
    end
  end

  // Control registers: tick, run state, slot pointer, clear sweep, position.
  assign k_next = cmd.k_clear ? '0 : (cmd.k_inc ? k + 1'b1 : k);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick       <= '0;
      run_accept <= 1'b0;
      run_slot   <= '0;
      clr_idx    <= '0;
      slot       <= '0;
      k          <= '0;
    end else begin
      k <= k_next;
      if (cmd.tick_inc) begin
        tick <= tick + 1'b1;
      end
      if (cmd.slot_from_mod) begin
        slot <= mod_rem;
      end else if (cmd.slot_from_run) begin
        slot <= run_slot;
      end
      if (cfg_hit) begin
        run_accept <= 1'b0;
        run_slot   <= '0;
        clr_idx    <= '0;
      end else begin
        if (cmd.run_clear) begin
          run_accept <= 1'b0;
        end else if (cmd.wb_decide && repl) begin
          run_accept <= 1'b1;
          run_slot   <= slot;
        end
        if (cmd.clear_step) begin
          clr_idx <= clr_idx + 1'b1;
        end
      end
    end
  end

  // Replacement decision on the slot read for position zero.
  assign repl = !meta_q.valid || ($signed(cap_score) < $signed(meta_q.score)) ||
                ({1'b0, tick} > ({1'b0, meta_q.age} + (TICK_W + 1)'(stale_window)));

  assign pos_bit = SEEDS_CAP'(1) << cap_pos[POS_W-1:0];

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = slot;
    meta_wdata = meta_q;
    seed_we    = 1'b0;
    seed_wpos  = cap_pos[POS_W-1:0];
    if (cmd.clear_step) begin
      meta_we    = 1'b1;
      meta_waddr = clr_idx;
      meta_wdata = '{valid: 1'b0, score: SCORE_INF, age: '0, mask: '0};
    end else if (cmd.wb_decide && repl) begin
      meta_we    = 1'b1;
      meta_wdata = '{valid: 1'b1, score: cap_score, age: tick,
                     mask: meta_q.mask | SEEDS_CAP'(1)};
      seed_we    = 1'b1;
      seed_wpos  = '0;
    end else if (cmd.wb_more) begin
      meta_we         = 1'b1;
      meta_wdata.mask = meta_q.mask | pos_bit;
      seed_we         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (cmd.meta_rd) begin
      meta_q <= meta_mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (seed_we) begin
      seed_mem[{slot, seed_wpos}] <= cap_seed;
    end
    seed_q <= seed_mem[{slot, k_next}];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_miss || cmd.emit_seed) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_miss) begin
      found    <= 1'b0;
      out_seed <= '0;
      out_pos  <= '0;
      last     <= 1'b1;
    end else if (cmd.emit_seed) begin
      found    <= 1'b1;
      out_seed <= meta_q.mask[k] ? seed_q : '0;
      out_pos  <= SPOS_W'(k);
      last     <= st.last_seed;
    end
  end

  always_comb begin
    st             = '0;
    st.req_lookup  = (kind == KIND_LOOKUP);
    st.req_pos0    = (seed_pos == '0);
    st.req_wb_ok   = !query_id[ID_W-1] && !seed_id[ID_W-1] && score_finite;
    st.req_more_ok = run_accept && ({1'b0, seed_pos} < 4'(nseeds));
    st.req_qid_neg = query_id[ID_W-1];
    st.mod_done    = mod_done;
    st.cap_lookup  = (cap_kind == KIND_LOOKUP);
    st.cap_pos0    = (cap_pos == '0);
    st.meta_valid  = meta_q.valid;
    st.last_seed   = ((NSEED_W'(k) + NSEED_W'(1)) == nseeds);
    st.out_free    = !rsp_valid || rsp_ready;
    st.clear_last  = (clr_idx == SLOT_W'(MAX_SLOTS - 1));
    st.cfg_hit     = cfg_hit;
  end

  // The remainder is a usable slot index.
  a_mod_in_range: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (CNT_W'(mod_rem) < eff_slots))
    else $error("slot index from the remainder unit is out of range");

  // A seed is only returned from a slot that was found valid.
  a_emit_valid_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_seed |-> meta_q.valid)
    else $error("seed returned from an empty slot");

  // The seed position never passes the configured count.
  a_pos_in_count: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_seed |-> (NSEED_W'(k) < nseeds))
    else $error("seed position beyond the seed count");

  // A replacing position-zero item opens the run on this slot.
  a_run_opened: assert property (@(posedge clk) disable iff (rst)
    (cmd.wb_decide && repl && !cfg_hit) |=> (run_accept && (run_slot == $past(slot))))
    else $error("replacement did not open the run");

endmodule

// File: sv/sst_ctrl.sv
// Controller of the seed slot table: sequences clearing, the remainder
// unit, metadata reads, writebacks and result emission. Depends on sst_pkg.
module sst_ctrl import sst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  sst_status_t st,
  output sst_cmd_t    cmd
);

  sst_state_t state;
  sst_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          if (st.req_lookup) begin
            if (st.req_qid_neg) begin
              state_next = S_MISS;
            end else begin
              cmd.mod_start = 1'b1;
              state_next    = S_MOD;
            end
          end else if (st.req_pos0) begin
            cmd.run_clear = 1'b1;
            if (st.req_wb_ok) begin
              cmd.tick_inc  = 1'b1;
              cmd.mod_start = 1'b1;
              state_next    = S_MOD;
            end
          end else if (st.req_more_ok) begin
            cmd.slot_from_run = 1'b1;
            state_next        = S_META_RD;
          end
        end
      end
      S_MOD: begin
        if (st.mod_done) begin
          cmd.slot_from_mod = 1'b1;
          state_next        = S_META_RD;
        end
      end
      S_META_RD: begin
        cmd.meta_rd = 1'b1;
        cmd.k_clear = 1'b1;
        if (st.cap_lookup) begin
          state_next = S_LK_META;
        end else if (st.cap_pos0) begin
          state_next = S_WB_DECIDE;
        end else begin
          state_next = S_WB_MASK;
        end
      end
      S_LK_META: begin
        state_next = st.meta_valid ? S_LK_OUT : S_MISS;
      end
      S_LK_OUT: begin
        if (st.out_free) begin
          cmd.emit_seed = 1'b1;
          cmd.k_inc     = 1'b1;
          if (st.last_seed) begin
            state_next = S_IDLE;
          end
        end
      end
      S_MISS: begin
        if (st.out_free) begin
          cmd.emit_miss = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_WB_DECIDE: begin
        cmd.wb_decide = 1'b1;
        state_next    = S_IDLE;
      end
      S_WB_MASK: begin
        cmd.wb_more = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (st.cfg_hit) begin
      state_next = S_CLEAR;
    end
  end

endmodule

// File: sv/seed_slot_table_score_aging.sv
// Seed slot table with score aging: a lookup runs the remainder unit and the
// registered metadata read before its first result, then gives one result per
// cycle while the output register is free; a position-zero writeback also
// runs the remainder unit (4 bits a cycle), a later position does not.
// After reset and after every write to a listed configuration register a
// clearing pass empties the table; no item is taken meanwhile.
module seed_slot_table_score_aging import sst_pkg::*; (
  input logic       clk,
  input logic       rst,
  sst_req_if.sink   req,
  sst_rsp_if.source rsp,
  sst_cfg_if.sink   cfg
);

  // Command and status buses between the sequencer and the datapath.
  sst_cmd_t    cmd;
  sst_status_t st;
  logic        req_ready;

  // Configuration writes are always taken; those to the listed registers land
  // in the datapath's registers and send the controller back to the clearing
  // pass. The tick counter survives them, the run state does not.
  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;

  // The controller takes one item at a time. It holds ready low while the
  // table is being cleared or an item is still being worked on, so the
  // payload fields seen by the datapath on an accepting edge belong to that
  // item and are captured there.
  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath keeps the slot metadata (valid mark, score, age and a mask
  // of the seed positions written since the last clear) in one memory and
  // the seed ids in another, addressed by slot and position. Results leave
  // through a one-entry output register, so result emission only stalls when
  // that register is still full and not being taken.
  sst_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .kind         (req.kind),
    .query_id     (req.query_id),
    .seed_id      (req.seed_id),
    .seed_pos     (req.seed_pos),
    .score        (req.score),
    .score_finite (req.score_finite),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .found        (rsp.found),
    .out_seed     (rsp.out_seed),
    .out_pos      (rsp.out_pos),
    .last         (rsp.last)
  );

endmodule
